FILE: design/hts_pkg.sv
// Shared constants, types and unit request/response structs for the hop transmit scheduler.
package hts_pkg;

    localparam int MAX_CHANNELS = 16;

    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int RND_W    = 32;
    localparam int FREQ_W   = 20;
    localparam int CNT_W    = 32;
    localparam int MODE_W   = 2;
    localparam int CHCNT_W  = 5;
    localparam int RATE_W   = 7;
    localparam int IDX_W    = $clog2(MAX_CHANNELS);
    localparam int SIZE_W   = $clog2(MAX_CHANNELS + 1);

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Shared divider: left-aligned dividend, narrow divisor and remainder.
    localparam int DIV_W    = 32;
    localparam int DIVR_W   = 7;
    localparam int DCNT_W   = $clog2(DIV_W + 1);

    localparam int US_PER_SEC    = 1000000;
    localparam int IVL_W         = 20;
    localparam int TWO_CH_OFFSET = 500;
    localparam int HALF_SPAN     = 2000;
    localparam int SPAN          = 4000;
    localparam int SPAN_W        = 12;

    localparam logic [DIV_W-1:0] IVL_DIVIDEND  = DIV_W'(US_PER_SEC) << (DIV_W - IVL_W);
    localparam logic [DIV_W-1:0] SPAN_DIVIDEND = DIV_W'(SPAN) << (DIV_W - SPAN_W);
    localparam logic [DCNT_W-1:0] IVL_STEPS    = DCNT_W'(IVL_W);
    localparam logic [DCNT_W-1:0] SPAN_STEPS   = DCNT_W'(SPAN_W);
    localparam logic [DCNT_W-1:0] RND_STEPS    = DCNT_W'(RND_W);

    typedef logic [OP_W-1:0]   t_opcode;
    typedef logic [MODE_W-1:0] t_mode;

    localparam t_opcode OP_START = 2'd0;
    localparam t_opcode OP_POLL  = 2'd1;
    localparam t_opcode OP_STOP  = 2'd2;

    localparam t_mode MODE_FIXED = 2'd0;
    localparam t_mode MODE_TWO   = 2'd1;

    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_CHCNT  = 2'd2;
    localparam logic [1:0] REG_RATE   = 2'd3;

    localparam logic [FREQ_W-1:0]  CENTER_RST = FREQ_W'(915000);
    localparam logic [RATE_W-1:0]  RATE_RST   = RATE_W'(10);

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    dividend;
        logic [DCNT_W-1:0]   steps;
        logic [DIVR_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_W-1:0]    quotient;
        logic [DIVR_W-1:0]   remainder;
    } t_div_rsp;

endpackage

FILE: design/hts_if.sv
// Request and result channel interfaces of the hop transmit scheduler.
interface hts_req_if;
    logic                         valid;
    logic                         ready;
    logic [hts_pkg::OP_W-1:0]     opcode;
    logic [hts_pkg::TIME_W-1:0]   now_us;
    logic [hts_pkg::RND_W-1:0]    random_value;

    modport source (output valid, opcode, now_us, random_value, input ready);
    modport sink   (input valid, opcode, now_us, random_value, output ready);
endinterface

interface hts_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         transmit_fire;
    logic                         retune;
    logic [hts_pkg::FREQ_W-1:0]   carrier_khz;
    logic [hts_pkg::CNT_W-1:0]    packets_sent;
    logic [hts_pkg::CNT_W-1:0]    hops_done;
    logic                         active;

    modport source (output valid, transmit_fire, retune, carrier_khz, packets_sent,
                    hops_done, active, input ready);
    modport sink   (input valid, transmit_fire, retune, carrier_khz, packets_sent,
                    hops_done, active, output ready);
endinterface

FILE: design/hts_div.sv
// Shared restoring divider: one quotient bit per cycle.
module hts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hts_pkg::t_div_req i_req,
    output hts_pkg::t_div_rsp o_rsp
);
    import hts_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_divisor;

    logic [DIVR_W:0]   w_trial;
    logic [DIVR_W:0]   w_diff;
    logic              w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_ge    = w_trial >= {1'b0, r_divisor};
        w_diff  = w_trial - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVR_W-1:0] : w_trial[DIVR_W-1:0];
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: design/hop_transmit_scheduler_top.sv
// Hop transmit scheduler top level: register port, sequencer, hop table and result register.
// A stop, an unknown opcode or a poll while stopped goes straight to the result. A poll
// runs the interval divide; if due, a two-channel hop then reads the table and a random
// hop first runs a 32-bit modulo divide. A start writes the table entries one by one, after
// a table-step divide in random mode. One request is in flight at a time. Reset (synchronous,
// active low) loads register defaults and clears control state, not table, working or result data.
module hop_transmit_scheduler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hts_pkg::PADDR_W-1:0]   paddr,
    input  logic [hts_pkg::PDATA_W-1:0]   pwdata,
    output logic [hts_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    hts_req_if.sink                       i_req,
    hts_rsp_if.source                     o_rsp
);
    import hts_pkg::*;

    // One-hot sequencer. Each divide state waits on the shared divider.
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DIV_TBL = 9'b000000010,
        S_BUILD   = 9'b000000100,
        S_DIV_IVL = 9'b000001000,
        S_CHECK   = 9'b000010000,
        S_DIV_MOD = 9'b000100000,
        S_READ    = 9'b001000000,
        S_RETUNE  = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    // Configuration registers.
    logic [FREQ_W-1:0]  r_center;
    t_mode              r_mode;
    logic [CHCNT_W-1:0] r_chcnt;
    logic [RATE_W-1:0]  r_rate;

    // Scheduler state.
    t_state             r_state;
    logic [SIZE_W-1:0]  r_table_size;
    logic [IDX_W-1:0]   r_chan_idx;
    logic [FREQ_W-1:0]  r_current;
    logic [TIME_W-1:0]  r_deadline;
    logic [CNT_W-1:0]   r_packets;
    logic [CNT_W-1:0]   r_hops;
    logic               r_running;
    logic               r_fire;
    logic               r_retune;

    // Per-request working registers.
    t_opcode            r_op;
    logic [TIME_W-1:0]  r_now;
    logic [RND_W-1:0]   r_rnd;
    logic [IVL_W-1:0]   r_ivl;
    logic [FREQ_W-1:0]  r_base;
    logic [SPAN_W-1:0]  r_q;
    logic [IDX_W-1:0]   r_r;
    logic [IDX_W-1:0]   r_d;
    logic [SPAN_W-1:0]  r_acc;
    logic [IDX_W-1:0]   r_frac;
    logic [IDX_W-1:0]   r_bld_idx;
    logic [SIZE_W-1:0]  r_bld_n;
    logic [FREQ_W-1:0]  r_rd_data;

    // Hop table, written during a build and read at the channel index.
    logic [FREQ_W-1:0]  r_table [MAX_CHANNELS];

    // Result register.
    logic               r_out_valid;
    logic               r_out_fire;
    logic               r_out_retune;
    logic [FREQ_W-1:0]  r_out_khz;
    logic [CNT_W-1:0]   r_out_packets;
    logic [CNT_W-1:0]   r_out_hops;
    logic               r_out_active;

    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    logic               w_cfg_wr;
    logic               w_accept;
    logic               w_random;
    logic [SIZE_W-1:0]  w_n;
    logic [FREQ_W-1:0]  w_base;
    logic [RATE_W-1:0]  w_rate;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_due;
    logic               w_hop;
    logic [IDX_W:0]     w_frac_sum;
    logic               w_carry;
    logic               w_out_free;

    hts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Register port. Writes complete in the access phase; pready is tied high.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_CENTER: prdata = PDATA_W'(r_center);
            REG_MODE:   prdata = PDATA_W'(r_mode);
            REG_CHCNT:  prdata = PDATA_W'(r_chcnt);
            REG_RATE:   prdata = PDATA_W'(r_rate);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RST;
            r_mode   <= MODE_FIXED;
            r_chcnt  <= '0;
            r_rate   <= RATE_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_CENTER: r_center <= pwdata[FREQ_W-1:0];
                REG_MODE:   r_mode   <= pwdata[MODE_W-1:0];
                REG_CHCNT:  r_chcnt  <= pwdata[CHCNT_W-1:0];
                REG_RATE:   r_rate   <= pwdata[RATE_W-1:0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    // Request side: one request is taken at a time, only from idle.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // Table geometry from the registers at start time. Mode three builds like random mode.
    always_comb begin
        w_random = (r_mode != MODE_FIXED) && (r_mode != MODE_TWO);
        if (SIZE_W'(r_chcnt) < SIZE_W'(2)) begin
            w_n = SIZE_W'(2);
        end else if (SIZE_W'(r_chcnt) > SIZE_W'(MAX_CHANNELS)) begin
            w_n = SIZE_W'(MAX_CHANNELS);
        end else begin
            w_n = SIZE_W'(r_chcnt);
        end
        if (r_mode == MODE_FIXED) begin
            w_base = r_center;
        end else if (r_mode == MODE_TWO) begin
            w_base = r_center - FREQ_W'(TWO_CH_OFFSET);
        end else begin
            w_base = r_center - FREQ_W'(HALF_SPAN);
        end
        // A zero rate is treated as one packet per second.
        w_rate = (r_rate == '0) ? RATE_W'(1) : r_rate;
    end

    // Poll decision and the running remainder of the table step.
    always_comb begin
        w_elapsed  = r_now - r_deadline;
        w_due      = w_elapsed >= TIME_W'(r_ivl);
        w_hop      = r_table_size > SIZE_W'(1);
        w_frac_sum = {1'b0, r_frac} + {1'b0, r_r};
        w_carry    = w_frac_sum >= {1'b0, r_d};
    end

    // Divider requests: table step at start, interval at poll, channel modulo on a random hop.
    always_comb begin
        w_div_req = '0;
        if (r_state == S_IDLE && w_accept) begin
            if (i_req.opcode == OP_START && w_random) begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = SPAN_DIVIDEND;
                w_div_req.steps    = SPAN_STEPS;
                w_div_req.divisor  = DIVR_W'(w_n - SIZE_W'(1));
            end else if (i_req.opcode == OP_POLL && r_running) begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = IVL_DIVIDEND;
                w_div_req.steps    = IVL_STEPS;
                w_div_req.divisor  = DIVR_W'(w_rate);
            end
        end else if (r_state == S_CHECK && w_due && w_hop && r_mode != MODE_TWO) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = DIV_W'(r_rnd);
            w_div_req.steps    = RND_STEPS;
            w_div_req.divisor  = DIVR_W'(r_table_size);
        end
    end

    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Sequencer and scheduler state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= '0;
            r_chan_idx   <= '0;
            r_current    <= '0;
            r_deadline   <= '0;
            r_packets    <= '0;
            r_hops       <= '0;
            r_running    <= 1'b0;
            r_fire       <= 1'b0;
            r_retune     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_fire   <= 1'b0;
                        r_retune <= 1'b0;
                        case (i_req.opcode)
                            OP_START: r_state <= w_random ? S_DIV_TBL : S_BUILD;
                            OP_POLL:  r_state <= r_running ? S_DIV_IVL : S_DONE;
                            OP_STOP: begin
                                r_running <= 1'b0;
                                r_state   <= S_DONE;
                            end
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_DIV_TBL: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    // Last entry written: the start completes and fires on entry zero.
                    if ({1'b0, r_bld_idx} == r_bld_n - SIZE_W'(1)) begin
                        r_table_size <= r_bld_n;
                        r_chan_idx   <= '0;
                        r_hops       <= '0;
                        r_retune     <= r_base != r_current;
                        r_current    <= r_base;
                        r_running    <= 1'b1;
                        r_deadline   <= r_now;
                        r_packets    <= CNT_W'(1);
                        r_fire       <= 1'b1;
                        r_state      <= S_DONE;
                    end
                end
                S_DIV_IVL: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_due) begin
                        r_deadline <= r_deadline + TIME_W'(r_ivl);
                        r_packets  <= r_packets + CNT_W'(1);
                        r_fire     <= 1'b1;
                        if (w_hop) begin
                            r_hops <= r_hops + CNT_W'(1);
                            if (r_mode == MODE_TWO) begin
                                r_chan_idx <= IDX_W'(!r_chan_idx[0]);
                                r_state    <= S_READ;
                            end else begin
                                r_state <= S_DIV_MOD;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV_MOD: begin
                    if (w_div_rsp.done) begin
                        r_chan_idx <= w_div_rsp.remainder[IDX_W-1:0];
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_RETUNE;
                end
                S_RETUNE: begin
                    if (r_rd_data != r_current) begin
                        r_current <= r_rd_data;
                        r_retune  <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_op      <= i_req.opcode;
            r_now     <= i_req.now_us;
            r_rnd     <= i_req.random_value;
            r_base    <= w_base;
            r_acc     <= '0;
            r_frac    <= '0;
            r_bld_idx <= '0;
            r_r       <= '0;
            if (r_mode == MODE_FIXED) begin
                r_q     <= '0;
                r_bld_n <= SIZE_W'(1);
                r_d     <= IDX_W'(1);
            end else if (r_mode == MODE_TWO) begin
                r_q     <= SPAN_W'(2 * TWO_CH_OFFSET);
                r_bld_n <= SIZE_W'(2);
                r_d     <= IDX_W'(1);
            end else begin
                r_q     <= '0;
                r_bld_n <= w_n;
                r_d     <= IDX_W'(w_n - SIZE_W'(1));
            end
        end else if (r_state == S_DIV_TBL && w_div_rsp.done) begin
            r_q <= w_div_rsp.quotient[SPAN_W-1:0];
            r_r <= w_div_rsp.remainder[IDX_W-1:0];
        end else if (r_state == S_BUILD) begin
            // Entry i sits at floor(i*span/d): add the quotient, carry the remainder.
            r_bld_idx <= r_bld_idx + IDX_W'(1);
            r_acc     <= r_acc + r_q + SPAN_W'(w_carry);
            r_frac    <= w_carry ? IDX_W'(w_frac_sum - {1'b0, r_d}) : w_frac_sum[IDX_W-1:0];
        end else if (r_state == S_DIV_IVL && w_div_rsp.done) begin
            r_ivl <= w_div_rsp.quotient[IVL_W-1:0];
        end
    end

    // Hop table storage.
    always_ff @(posedge i_clk) begin
        if (r_state == S_BUILD) begin
            r_table[r_bld_idx] <= r_base + FREQ_W'(r_acc);
        end
        r_rd_data <= r_table[r_chan_idx];
    end

    // Result register: loaded once per request, held until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_fire    <= r_fire;
            r_out_retune  <= r_retune;
            r_out_khz     <= r_current;
            r_out_packets <= r_packets;
            r_out_hops    <= r_hops;
            r_out_active  <= r_running;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.transmit_fire = r_out_fire;
    assign o_rsp.retune        = r_out_retune;
    assign o_rsp.carrier_khz   = r_out_khz;
    assign o_rsp.packets_sent  = r_out_packets;
    assign o_rsp.hops_done     = r_out_hops;
    assign o_rsp.active        = r_out_active;

    // The divider is never restarted while it is still working.
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    // A running scheduler always has a table of one to the maximum entries.
    a_table_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_table_size != '0 && r_table_size <= SIZE_W'(MAX_CHANNELS)))
        else $error("table size out of range while running");

    // A retune is only reported together with a transmission.
    a_retune_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_retune) |-> r_fire)
        else $error("retune without transmit");

    // A transmission only happens when the scheduler is running.
    a_fire_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_fire) |-> r_running)
        else $error("transmit while stopped");

    // A stop request always leaves the scheduler stopped.
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_op == OP_STOP) |-> !r_running)
        else $error("stop did not clear the running flag");

endmodule
